### sv/playback_buffer_watermark_fsm_unit_macros.svh
// Assertion helpers for the controller file.
// Both expect clk and rst_n in the scope where they are used.
`ifndef PLAYBACK_BUFFER_WATERMARK_FSM_UNIT_MACROS_SVH
`define PLAYBACK_BUFFER_WATERMARK_FSM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pbwf_pkg.sv
package pbwf_pkg;

  typedef enum logic [2:0] {
    ST_STOPPED = 3'd0,
    ST_PREBUF  = 3'd1,
    ST_PLAYING = 3'd2,
    ST_REBUF   = 3'd3,
    ST_STALLED = 3'd4
  } pbwf_state_t;

  localparam logic [2:0] FN_LEVEL  = 3'd0;
  localparam logic [2:0] FN_PACKET = 3'd1;
  localparam logic [2:0] FN_START  = 3'd2;
  localparam logic [2:0] FN_RESET  = 3'd3;
  localparam logic [2:0] FN_TICK   = 3'd4;

  localparam logic [2:0] CFG_LIVE     = 3'd0;
  localparam logic [2:0] CFG_LOW      = 3'd1;
  localparam logic [2:0] CFG_HIGH     = 3'd2;
  localparam logic [2:0] CFG_DEBOUNCE = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT  = 3'd4;

  localparam logic [15:0] LOW_RST      = 16'd750;
  localparam logic [15:0] HIGH_RST     = 16'd1950;
  localparam logic [15:0] DEBOUNCE_RST = 16'd300;
  localparam logic [15:0] TIMEOUT_RST  = 16'd5000;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] level;
  } pbwf_item_t;

  typedef struct packed {
    pbwf_state_t state;
    logic        blocked;
    logic        enter;
    logic        exit;
    logic [15:0] stall_total;
    logic [15:0] underrun_total;
    logic [15:0] episode_total;
    logic [31:0] buffering_time;
    logic [14:0] level_now;
  } pbwf_result_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

### sv/pbwf_in_stage.sv
module pbwf_in_stage import pbwf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [15:0] in_buffered_level_ms,
  input  logic               advance,
  output logic               go,
  output pbwf_item_t         item
);

  logic       vld_r;
  pbwf_item_t item_r;

  assign in_stall = vld_r && !advance;
  assign go       = vld_r && advance;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.func  <= in_func;
      item_r.level <= in_buffered_level_ms;
    end
  end

endmodule

### sv/pbwf_ctrl.sv
`include "playback_buffer_watermark_fsm_unit_macros.svh"

module pbwf_ctrl import pbwf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  pbwf_item_t   item,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  output pbwf_result_t result
);

  // Configuration
  logic        live_r;
  logic [15:0] low_r, high_r, deb_r, timeout_r;

  // Machine state
  pbwf_state_t st_r, st_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] since_r, since_nxt;
  logic        low_run_r, low_run_nxt;
  logic [31:0] low_tmr_r, low_tmr_nxt;
  logic        ep_run_r, ep_run_nxt;
  logic [31:0] ep_time_r, ep_time_nxt;
  logic [15:0] stall_cnt_r, stall_cnt_nxt;
  logic [15:0] under_cnt_r, under_cnt_nxt;
  logic [15:0] ep_cnt_r, ep_cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [14:0] level_r, level_nxt;
  logic        enter_nxt, exit_nxt;

  logic [14:0] lvl;
  logic        lt_low, ge_high, stall_hit, deb_done, pkt_back, level_live;
  logic [32:0] acc_sum;

  assign lvl        = item.level[15] ? '0 : item.level[14:0];
  assign lt_low     = {1'b0, lvl} < low_r;
  assign ge_high    = {1'b0, lvl} >= high_r;
  assign stall_hit  = (timeout_r != '0) && seen_r && (since_r > {16'd0, timeout_r});
  assign deb_done   = low_tmr_r >= {16'd0, deb_r};
  assign pkt_back   = seen_r && (since_r <= {16'd0, timeout_r});
  assign level_live = go && (item.func == FN_LEVEL) && live_r;
  assign acc_sum    = {1'b0, acc_r} + {1'b0, ep_time_r};

  // Next state.
  always_comb begin
    st_nxt = st_r;
    if (go) begin
      case (item.func)
        FN_LEVEL: begin
          if (live_r) begin
            if (stall_hit) begin
              if (st_r inside {ST_PLAYING, ST_REBUF}) begin
                st_nxt = ST_STALLED;
              end
            end else begin
              case (st_r)
                ST_PREBUF, ST_REBUF: begin
                  if (ge_high) begin
                    st_nxt = ST_PLAYING;
                  end
                end
                ST_PLAYING: begin
                  if (lt_low && low_run_r && deb_done) begin
                    st_nxt = ST_REBUF;
                  end
                end
                ST_STALLED: begin
                  if (pkt_back) begin
                    st_nxt = ST_PREBUF;
                  end
                end
                default: st_nxt = st_r;
              endcase
            end
          end
        end
        FN_START: begin
          if (live_r) begin
            st_nxt = ST_PREBUF;
          end
        end
        FN_RESET: st_nxt = live_r ? ST_STOPPED : ST_PLAYING;
        default:  st_nxt = st_r;
      endcase
    end
    // Turning the machine off parks it in playing.
    if (cfg_we && (cfg_index == CFG_LIVE) && !cfg_wdata[0]) begin
      st_nxt = ST_PLAYING;
    end
  end

  // Timers, counters and pulses.
  always_comb begin
    seen_nxt      = seen_r;
    since_nxt     = since_r;
    low_run_nxt   = low_run_r;
    low_tmr_nxt   = low_tmr_r;
    ep_run_nxt    = ep_run_r;
    ep_time_nxt   = ep_time_r;
    stall_cnt_nxt = stall_cnt_r;
    under_cnt_nxt = under_cnt_r;
    ep_cnt_nxt    = ep_cnt_r;
    acc_nxt       = acc_r;
    level_nxt     = level_r;
    enter_nxt     = 1'b0;
    exit_nxt      = 1'b0;
    if (go) begin
      case (item.func)
        FN_LEVEL: begin
          level_nxt = lvl;
          if (live_r) begin
            if (stall_hit) begin
              if (st_r inside {ST_PLAYING, ST_REBUF}) begin
                enter_nxt     = 1'b1;
                stall_cnt_nxt = sat_inc16(stall_cnt_r);
                ep_cnt_nxt    = sat_inc16(ep_cnt_r);
                if (!ep_run_r) begin
                  ep_run_nxt  = 1'b1;
                  ep_time_nxt = '0;
                end
              end
            end else if (st_r == ST_PLAYING) begin
              if (lt_low) begin
                if (!low_run_r) begin
                  low_run_nxt = 1'b1;
                  low_tmr_nxt = '0;
                end else if (deb_done) begin
                  low_run_nxt   = 1'b0;
                  low_tmr_nxt   = '0;
                  enter_nxt     = 1'b1;
                  under_cnt_nxt = sat_inc16(under_cnt_r);
                  ep_cnt_nxt    = sat_inc16(ep_cnt_r);
                  if (!ep_run_r) begin
                    ep_run_nxt  = 1'b1;
                    ep_time_nxt = '0;
                  end
                end
              end else begin
                low_run_nxt = 1'b0;
                low_tmr_nxt = '0;
              end
            end else if ((st_r inside {ST_PREBUF, ST_REBUF}) && ge_high) begin
              low_run_nxt = 1'b0;
              low_tmr_nxt = '0;
              exit_nxt    = 1'b1;
              if (ep_run_r) begin
                acc_nxt     = acc_sum[32] ? '1 : acc_sum[31:0];
                ep_run_nxt  = 1'b0;
                ep_time_nxt = '0;
              end
            end else if ((st_r == ST_STALLED) && pkt_back) begin
              low_run_nxt = 1'b0;
              low_tmr_nxt = '0;
            end
          end
        end
        FN_PACKET: begin
          seen_nxt  = 1'b1;
          since_nxt = '0;
        end
        FN_START: begin
          if (live_r) begin
            seen_nxt    = 1'b1;
            since_nxt   = '0;
            low_run_nxt = 1'b0;
            low_tmr_nxt = '0;
            if (!ep_run_r) begin
              ep_run_nxt  = 1'b1;
              ep_time_nxt = '0;
            end
          end
        end
        FN_RESET: begin
          seen_nxt      = 1'b0;
          since_nxt     = '0;
          low_run_nxt   = 1'b0;
          low_tmr_nxt   = '0;
          ep_run_nxt    = 1'b0;
          ep_time_nxt   = '0;
          stall_cnt_nxt = '0;
          under_cnt_nxt = '0;
          ep_cnt_nxt    = '0;
          acc_nxt       = '0;
        end
        FN_TICK: begin
          if (seen_r) begin
            since_nxt = sat_inc32(since_r);
          end
          if (low_run_r) begin
            low_tmr_nxt = sat_inc32(low_tmr_r);
          end
          if (ep_run_r) begin
            ep_time_nxt = sat_inc32(ep_time_r);
          end
        end
        default: level_nxt = level_r;
      endcase
    end
  end

  always_comb begin
    result.state          = st_nxt;
    result.blocked        = st_nxt inside {ST_PREBUF, ST_REBUF, ST_STALLED};
    result.enter          = enter_nxt;
    result.exit           = exit_nxt;
    result.stall_total    = stall_cnt_nxt;
    result.underrun_total = under_cnt_nxt;
    result.episode_total  = ep_cnt_nxt;
    result.buffering_time = acc_nxt;
    result.level_now      = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= 1'b1;
      low_r     <= LOW_RST;
      high_r    <= HIGH_RST;
      deb_r     <= DEBOUNCE_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIVE:     live_r    <= cfg_wdata[0];
        CFG_LOW:      low_r     <= cfg_wdata;
        CFG_HIGH:     high_r    <= cfg_wdata;
        CFG_DEBOUNCE: deb_r     <= cfg_wdata;
        CFG_TIMEOUT:  timeout_r <= cfg_wdata;
        default:      live_r    <= live_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_STOPPED;
      seen_r      <= 1'b0;
      since_r     <= '0;
      low_run_r   <= 1'b0;
      low_tmr_r   <= '0;
      ep_run_r    <= 1'b0;
      ep_time_r   <= '0;
      stall_cnt_r <= '0;
      under_cnt_r <= '0;
      ep_cnt_r    <= '0;
      acc_r       <= '0;
      level_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      seen_r      <= seen_nxt;
      since_r     <= since_nxt;
      low_run_r   <= low_run_nxt;
      low_tmr_r   <= low_tmr_nxt;
      ep_run_r    <= ep_run_nxt;
      ep_time_r   <= ep_time_nxt;
      stall_cnt_r <= stall_cnt_nxt;
      under_cnt_r <= under_cnt_nxt;
      ep_cnt_r    <= ep_cnt_nxt;
      acc_r       <= acc_nxt;
      level_r     <= level_nxt;
    end
  end

  `PBWF_ASSERT_NOW(a_off_holds_playing, !live_r, st_r == ST_PLAYING, "disabled machine left playing")
  `PBWF_ASSERT_NOW(a_enter_target, go && result.enter,
    result.state == ST_REBUF || result.state == ST_STALLED, "enter pulse without buffering entry")
  `PBWF_ASSERT_NOW(a_episodes_cover, 1'b1,
    ep_cnt_r >= stall_cnt_r && ep_cnt_r >= under_cnt_r, "episode count below its parts")
  `PBWF_ASSERT_NEXT(a_acc_monotonic, !(go && item.func == FN_RESET),
    acc_r >= $past(acc_r), "buffering time decreased without a session reset")

endmodule

### sv/pbwf_out_stage.sv
module pbwf_out_stage import pbwf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  pbwf_result_t result,
  output logic         advance,
  output logic         out_valid,
  input  logic         out_stall,
  output pbwf_result_t out_res
);

  logic         vld_r;
  pbwf_result_t res_r;

  // The register frees up when it is empty or its result leaves this cycle.
  assign advance   = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= result;
    end
  end

endmodule

### sv/playback_buffer_watermark_fsm_unit.sv
// Channel   Handshake             Moves
// in_       in_valid / in_stall   one request: func and buffered level
// out_      out_valid / out_stall one result per request: state, pulses, totals
// cfg_      cfg_we                one register write: index and data
//
// One request per cycle sustained while out_ is not stalled; a taken request is held in the
// input register, then its result is held in the result register, and from there it is on out_.
// The state update is a single combinational pass between those two registers.
// rst_n is synchronous; it restores the register defaults and the stopped state.
// A stall on out_ holds the result register; in_ stalls only while the input register
// also holds a request that cannot move on.
module playback_buffer_watermark_fsm_unit import pbwf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [15:0] in_buffered_level_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_machine_state,
  output logic               out_consume_blocked,
  output logic               out_enter_pulse,
  output logic               out_exit_pulse,
  output logic [15:0]        out_stall_total,
  output logic [15:0]        out_underrun_total,
  output logic [15:0]        out_episode_total,
  output logic [31:0]        out_buffering_time_ms,
  output logic [14:0]        out_level_now_ms,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic         advance, go;
  pbwf_item_t   item;
  pbwf_result_t result, out_res;

  pbwf_in_stage u_in (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_buffered_level_ms (in_buffered_level_ms),
    .advance              (advance),
    .go                   (go),
    .item                 (item)
  );

  pbwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  pbwf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_machine_state     = out_res.state;
  assign out_consume_blocked   = out_res.blocked;
  assign out_enter_pulse       = out_res.enter;
  assign out_exit_pulse        = out_res.exit;
  assign out_stall_total       = out_res.stall_total;
  assign out_underrun_total    = out_res.underrun_total;
  assign out_episode_total     = out_res.episode_total;
  assign out_buffering_time_ms = out_res.buffering_time;
  assign out_level_now_ms      = out_res.level_now;

endmodule
